>>> sv/sitda_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Holds widths, character codes and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package sitda_pkg;

	localparam int VALUE_WIDTH = 32;
	// decimal digits of 2^VALUE_WIDTH: floor(W * log10(2)) + 1
	localparam int NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int PTR_W = (NDIG > 1) ? $clog2(NDIG) : 1;
	localparam int CNT_W = $clog2(VALUE_WIDTH);
	localparam int BCD_W = NDIG * 4;

	localparam logic [6:0] ASCII_ZERO = 7'd48;
	localparam logic [6:0] ASCII_MINUS = 7'd45;

	typedef struct packed {
		logic load;
		logic shift;
		logic find;
		logic emit_sign;
		logic emit_digit;
	} dp_cmd_t;

	typedef struct packed {
		logic neg;
		logic ptr_zero;
	} dp_sts_t;

endpackage

`default_nettype wire

>>> sv/sitda_dp.sv
// Datapath: magnitude register, double-dabble BCD converter, digit pointer
// and registered character output. Depends on sitda_pkg.
`default_nettype none

module sitda_dp
	import sitda_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic signed [VALUE_WIDTH-1:0] value,
	input  wire dp_cmd_t                       cmd,
	output dp_sts_t                            sts,
	output logic [6:0]                         char_code,
	output logic                               last,
	output logic                               char_valid
);

	logic [VALUE_WIDTH-1:0] mag_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [BCD_W-1:0]       bcd_adj;
	logic                   neg_q;
	logic [PTR_W-1:0]       ptr_q;
	logic [PTR_W-1:0]       top_idx;
	logic [3:0]             cur_digit;
	logic [6:0]             char_q;
	logic                   last_q;
	logic                   valid_q;

	// add 3 to every BCD digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	// most significant nonzero digit, zero if none
	always_comb begin
		top_idx = '0;
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*4 +: 4] != 4'd0) begin
				top_idx = PTR_W'(i);
			end
		end
	end

	assign cur_digit = bcd_q[ptr_q*4 +: 4];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= value[VALUE_WIDTH-1];
			if (value[VALUE_WIDTH-1]) begin
				mag_q <= ~value + 1'b1;
			end else begin
				mag_q <= value;
			end
			bcd_q <= '0;
		end else if (cmd.shift) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_WIDTH-1]};
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
		end
		if (cmd.find) begin
			ptr_q <= top_idx;
		end else if (cmd.emit_digit) begin
			ptr_q <= ptr_q - 1'b1;
		end
		if (cmd.emit_sign) begin
			char_q <= ASCII_MINUS;
			last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= ASCII_ZERO + {3'b000, cur_digit};
			last_q <= (ptr_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.emit_sign | cmd.emit_digit;
		end
	end

	assign sts.neg      = neg_q;
	assign sts.ptr_zero = (ptr_q == '0);
	assign char_code    = char_q;
	assign last         = last_q;
	assign char_valid   = valid_q;

	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit_sign && cmd.emit_digit))
		else $error("sign and digit emitted together");

	a_last_is_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && last) |-> (char_code >= ASCII_ZERO && char_code <= ASCII_ZERO + 7'd9))
		else $error("last character is not a digit");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_digit |-> (cur_digit <= 4'd9))
		else $error("BCD digit out of range");

endmodule

`default_nettype wire

>>> sv/sitda_ctrl.sv
// Controller: sequences load, shift passes, digit search and character emission.
// Depends on sitda_pkg.
`default_nettype none

module sitda_ctrl
	import sitda_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd,
	output logic         busy
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CONV,
		S_FIND,
		S_SIGN,
		S_DIGITS
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_CONV;
						cnt_q   <= CNT_W'(VALUE_WIDTH - 1);
						busy_q  <= 1'b1;
					end
				end
				S_CONV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= S_FIND;
					end
				end
				S_FIND: begin
					state_q <= sts.neg ? S_SIGN : S_DIGITS;
				end
				S_SIGN: begin
					state_q <= S_DIGITS;
				end
				S_DIGITS: begin
					if (sts.ptr_zero) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.load       = (state_q == S_IDLE) && start;
		cmd.shift      = (state_q == S_CONV);
		cmd.find       = (state_q == S_FIND);
		cmd.emit_sign  = (state_q == S_SIGN);
		cmd.emit_digit = (state_q == S_DIGITS);
	end

	assign busy = busy_q;

	a_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == (state_q != S_IDLE))
		else $error("busy out of step with state");

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && state_q == S_CONV))
		else $error("transfer not taken");

	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIGITS && sts.ptr_zero) |=> !busy)
		else $error("busy held after last character");

endmodule

`default_nettype wire

>>> sv/signed_int_to_decimal_ascii.sv
// Top level of the signed integer to decimal ASCII converter.
// Instantiates sitda_ctrl and sitda_dp; depends on sitda_pkg.
//
// A transfer takes place at a rising edge with start high and busy low. The
// magnitude is converted by a double-dabble loop of one bit per cycle, then the
// block finds the most significant digit and emits the characters (sign, then
// digits without leading zeros), staying busy until it has emitted the last.
// Each character appears for one cycle with char_valid high and last marking
// the final one; the receiver cannot stall the output.
`default_nettype none

module signed_int_to_decimal_ascii
	import sitda_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic signed [VALUE_WIDTH-1:0] value,
	output logic                               busy,
	output logic [6:0]                         char_code,
	output logic                               last,
	output logic                               char_valid
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	sitda_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	sitda_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (value),
		.cmd        (cmd),
		.sts        (sts),
		.char_code  (char_code),
		.last       (last),
		.char_valid (char_valid)
	);

endmodule

`default_nettype wire
